// ===== hw/rtl/rps_pkg.sv =====
// ----------------------------------------------------------------------------
// Reflow profile setpoint package
// Shared widths, codes and types for the reflow profile setpoint block.
// ----------------------------------------------------------------------------
package rps_pkg;

  localparam int TIME_BITS = 20;
  localparam int TEMP_W    = 9;
  localparam int RAMP_W    = 20;
  localparam int DUTY_W    = 7;
  localparam int CFG_W     = 56;
  localparam int PROD_W    = TEMP_W + RAMP_W;
  localparam int CNT_W     = $clog2(TEMP_W);

  localparam logic [DUTY_W-1:0] DUTY_MAX = DUTY_W'(100);

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_PREHEAT = 2'd1,
    PH_SOAK    = 2'd2,
    PH_REFLOW  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_ABORT = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    REG_PREHEAT = 2'd0,
    REG_SOAK    = 2'd1,
    REG_REFLOW  = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_WAIT,
    S_EMIT
  } ctrl_state_e;

  typedef enum logic [1:0] {
    U_IDLE,
    U_MUL,
    U_DIV
  } unit_state_e;

  // Bit layout matches the configuration word, most significant field first.
  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic [RAMP_W-1:0] runtime;
    logic [RAMP_W-1:0] ramp;
    logic [TEMP_W-1:0] target;
  } phase_cfg_t;

  typedef struct packed {
    logic              start;
    logic [TEMP_W-1:0] mag;
    logic [RAMP_W-1:0] mult;
    logic [RAMP_W-1:0] ramp;
  } unit_req_t;

  typedef struct packed {
    logic              done;
    logic [TEMP_W-1:0] quot;
    logic              rem_nz;
  } unit_rsp_t;

endpackage

// ===== hw/rtl/rps_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Phase configuration registers
// Holds the three packed phase words and selects the one for a given phase.
// ----------------------------------------------------------------------------
module rps_cfg_regs import rps_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  phase_e           phase_sel_i,
  output phase_cfg_t       phase_cfg_o
);

  logic [CFG_W-1:0] preheat_q, soak_q, reflow_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      preheat_q <= '0;
      soak_q    <= '0;
      reflow_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_PREHEAT: preheat_q <= cfg_wdata_i;
        REG_SOAK:    soak_q    <= cfg_wdata_i;
        REG_REFLOW:  reflow_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (phase_sel_i)
      PH_PREHEAT: phase_cfg_o = phase_cfg_t'(preheat_q);
      PH_SOAK:    phase_cfg_o = phase_cfg_t'(soak_q);
      default:    phase_cfg_o = phase_cfg_t'(reflow_q);
    endcase
  end

endmodule

// ===== hw/rtl/rps_ramp_unit.sv =====
// ----------------------------------------------------------------------------
// Ramp interpolation unit
// Computes mag * mult / ramp with one shared adder: shift-add multiply, then
// restoring division, one bit per cycle.
// ----------------------------------------------------------------------------
module rps_ramp_unit import rps_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  unit_req_t req_i,
  output unit_rsp_t rsp_o
);

  unit_state_e       state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [PROD_W-1:0] acc_q, acc_d;
  logic [TEMP_W-1:0] quot_q, quot_d;
  logic [TEMP_W-1:0] mag_q;
  logic [RAMP_W-1:0] mult_q, ramp_q;
  logic              done_q, done_d;

  logic [PROD_W-1:0] add_a, add_b;
  logic              add_sub;
  logic [PROD_W:0]   add_sum;

  // The single shared adder and subtractor.
  assign add_sum = {1'b0, add_a} + ({1'b0, add_b} ^ {(PROD_W + 1){add_sub}})
                   + (PROD_W + 1)'(add_sub);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    quot_d  = quot_q;
    done_d  = 1'b0;
    add_a   = acc_q;
    add_b   = '0;
    add_sub = 1'b0;
    case (state_q)
      U_IDLE: begin
        if (req_i.start) begin
          state_d = U_MUL;
          cnt_d   = CNT_W'(TEMP_W - 1);
          acc_d   = '0;
          quot_d  = '0;
        end
      end
      U_MUL: begin
        add_a = {acc_q[PROD_W-2:0], 1'b0};
        add_b = mag_q[cnt_q[CNT_W-1:0]] ? PROD_W'(mult_q) : '0;
        acc_d = add_sum[PROD_W-1:0];
        if (cnt_q == '0) begin
          state_d = U_DIV;
          cnt_d   = CNT_W'(TEMP_W - 1);
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      U_DIV: begin
        add_sub = 1'b1;
        add_b   = PROD_W'(ramp_q) << cnt_q;
        if (!add_sum[PROD_W]) begin
          acc_d          = add_sum[PROD_W-1:0];
          quot_d[cnt_q]  = 1'b1;
        end
        if (cnt_q == '0) begin
          state_d = U_IDLE;
          done_d  = 1'b1;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      default: state_d = U_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    quot_q <= quot_d;
    if (state_q == U_IDLE && req_i.start) begin
      mag_q  <= req_i.mag;
      mult_q <= req_i.mult;
      ramp_q <= req_i.ramp;
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.quot   = quot_q;
  assign rsp_o.rem_nz = |acc_q;

endmodule

// ===== hw/rtl/reflow_profile_setpoint.sv =====
// ----------------------------------------------------------------------------
// Reflow profile setpoint sequencer
// Runs preheat, soak and reflow phases and reports a ramped setpoint per item.
// ----------------------------------------------------------------------------
// Items arrive on the input channel (valid/ready) as an op code: a
// one-millisecond tick, a start with its starting temperature, or an abort.
// Every accepted item yields exactly one result item on the output channel
// (valid/ready) with the setpoint, phase, duty limit and duty valid flag.
// The phase state is updated at the edge that accepts the item. The setpoint
// is then interpolated by a shared adder: a shift-add multiply, then a
// restoring division; in idle, or with a zero ramp, the unit is skipped.
// Input ready is high only while no item is being worked on, so a new item
// is taken only once the previous result is in the output register. The
// result sits in an output register, so a new item is accepted while the
// previous result still waits; if the receiver stalls, the finished result of
// the next item is held back until the output register is free. Reset clears
// the phase registers to zero and returns the block to idle. Configuration
// writes are registered directly from the write port.
// ----------------------------------------------------------------------------
module reflow_profile_setpoint import rps_pkg::*; #(
  parameter int TimeBits = TIME_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        op_i,
  input  logic [TEMP_W-1:0] start_temp_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [TEMP_W-1:0] setpoint_o,
  output logic [1:0]        phase_o,
  output logic [DUTY_W-1:0] duty_limit_o,
  output logic              duty_valid_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i
);

  localparam int CmpW = (TimeBits > RAMP_W) ? TimeBits : RAMP_W;

  ctrl_state_e         state_q, state_d;
  phase_e              phase_q, phase_d, phase_next;
  logic [TimeBits-1:0] elapsed_q, elapsed_d, el_inc;
  logic [TEMP_W-1:0]   base_q, base_d;
  phase_cfg_t          cur_cfg;
  unit_req_t           unit_req;
  unit_rsp_t           unit_rsp;

  logic                accept, prep, load_out;
  logic                direct_q, neg_q;
  logic [TEMP_W-1:0]   dval_q;
  logic [CmpW-1:0]     el_inc_ext, el_ext, runtime_ext, ramp_ext;
  logic [RAMP_W-1:0]   t_sel;
  logic [TEMP_W:0]     adj_mag;
  logic [TEMP_W-1:0]   sp_calc, sp_final;
  logic [DUTY_W-1:0]   duty_clamped;

  logic                out_valid_q;
  logic [TEMP_W-1:0]   setpoint_q;
  phase_e              phase_out_q;
  logic [DUTY_W-1:0]   duty_q;
  logic                duty_valid_q;

  rps_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .phase_sel_i (phase_q),
    .phase_cfg_o (cur_cfg)
  );

  rps_ramp_unit u_ramp_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (unit_req),
    .rsp_o  (unit_rsp)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Phase state update on an accepted item.
  assign el_inc      = (&elapsed_q) ? elapsed_q : elapsed_q + 1'b1;
  assign el_inc_ext  = CmpW'(el_inc);
  assign runtime_ext = CmpW'(cur_cfg.runtime);

  always_comb begin
    case (phase_q)
      PH_PREHEAT: phase_next = PH_SOAK;
      PH_SOAK:    phase_next = PH_REFLOW;
      default:    phase_next = PH_IDLE;
    endcase
  end

  always_comb begin
    phase_d   = phase_q;
    elapsed_d = elapsed_q;
    base_d    = base_q;
    if (accept) begin
      case (op_e'(op_i))
        OP_START: begin
          phase_d   = PH_PREHEAT;
          elapsed_d = '0;
          base_d    = start_temp_i;
        end
        OP_ABORT: begin
          phase_d   = PH_IDLE;
          elapsed_d = '0;
          base_d    = '0;
        end
        OP_TICK: begin
          if (phase_q != PH_IDLE) begin
            if (el_inc_ext > runtime_ext) begin
              phase_d   = phase_next;
              elapsed_d = '0;
              base_d    = (phase_next == PH_IDLE) ? '0 : cur_cfg.target;
            end else begin
              elapsed_d = el_inc;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Operands for the interpolation.
  assign el_ext   = CmpW'(elapsed_q);
  assign ramp_ext = CmpW'(cur_cfg.ramp);
  assign t_sel    = (el_ext < ramp_ext) ? el_ext[RAMP_W-1:0] : cur_cfg.ramp;

  assign unit_req.start = prep && (phase_q != PH_IDLE) && (cur_cfg.ramp != '0);
  assign unit_req.mag   = (base_q > cur_cfg.target) ? base_q - cur_cfg.target
                                                    : cur_cfg.target - base_q;
  assign unit_req.mult  = t_sel;
  assign unit_req.ramp  = cur_cfg.ramp;

  // A falling ramp rounds the quotient towards minus infinity.
  assign adj_mag  = {1'b0, unit_rsp.quot} + (TEMP_W + 1)'(unit_rsp.rem_nz);
  assign sp_calc  = neg_q ? base_q - adj_mag[TEMP_W-1:0] : base_q + unit_rsp.quot;
  assign sp_final = direct_q ? dval_q : sp_calc;

  assign duty_clamped = (cur_cfg.duty > DUTY_MAX) ? DUTY_MAX : cur_cfg.duty;

  always_comb begin
    state_d  = state_q;
    prep     = 1'b0;
    load_out = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_PREP;
      end
      S_PREP: begin
        prep    = 1'b1;
        state_d = unit_req.start ? S_WAIT : S_EMIT;
      end
      S_WAIT: begin
        if (unit_rsp.done) state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_IDLE;
      elapsed_q   <= '0;
      base_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      elapsed_q <= elapsed_d;
      base_q    <= base_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (prep) begin
      direct_q <= !unit_req.start;
      neg_q    <= base_q > cur_cfg.target;
      dval_q   <= (phase_q == PH_IDLE) ? '0 : cur_cfg.target;
    end
    if (load_out) begin
      setpoint_q   <= sp_final;
      phase_out_q  <= phase_q;
      duty_q       <= (phase_q == PH_IDLE) ? '0 : duty_clamped;
      duty_valid_q <= (phase_q != PH_IDLE);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign setpoint_o   = setpoint_q;
  assign phase_o      = phase_out_q;
  assign duty_limit_o = duty_q;
  assign duty_valid_o = duty_valid_q;

  a_duty_valid_matches_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (duty_valid_o == (phase_o != PH_IDLE)))
    else $error("duty valid flag disagrees with reported phase");

  a_idle_result_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && phase_o == PH_IDLE) |-> (setpoint_o == '0 && duty_limit_o == '0))
    else $error("idle result carries a nonzero setpoint or duty");

  a_duty_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (duty_limit_o <= DUTY_MAX))
    else $error("duty limit above the clamp");

  a_unit_done_when_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    unit_rsp.done |-> (state_q == S_WAIT))
    else $error("interpolation finished outside the wait state");

  a_start_restarts_profile: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op_i == OP_START) |=> (phase_q == PH_PREHEAT && elapsed_q == '0))
    else $error("start item did not restart the profile");

endmodule

// ===== bench/reflow_profile_setpoint_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reflow profile setpoint checker
// Follows the write port and both channels of the sequencer, keeps its own
// copy of the phase registers and the phase timer, works out the heater
// command that each accepted item must produce and compares every delivered
// result item, field by field, with the oldest command still outstanding.
// ----------------------------------------------------------------------------
module reflow_profile_setpoint_checker import rps_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [1:0]        op_i,
  input  logic [TEMP_W-1:0] start_temp_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [TEMP_W-1:0] setpoint_i,
  input  logic [1:0]        phase_i,
  input  logic [DUTY_W-1:0] duty_limit_i,
  input  logic              duty_valid_i,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  output int                pending_o,
  output int                fail_count_o
);

  typedef struct packed {
    logic [TEMP_W-1:0] setpoint;
    logic [1:0]        phase;
    logic [DUTY_W-1:0] duty_limit;
    logic              duty_valid;
  } heater_cmd_t;

  phase_cfg_t           profile [3];
  phase_e               cur_phase;
  logic [TIME_BITS-1:0] elapsed_ms;
  logic [TEMP_W-1:0]    base_temp;
  heater_cmd_t          expected_cmds [$];
  int                   fails;

  function automatic phase_cfg_t active_cfg();
    case (cur_phase)
      PH_PREHEAT: return profile[REG_PREHEAT];
      PH_SOAK:    return profile[REG_SOAK];
      default:    return profile[REG_REFLOW];
    endcase
  endfunction

  function automatic heater_cmd_t next_heater_cmd(input logic [1:0]        op,
                                                  input logic [TEMP_W-1:0] temp);
    phase_cfg_t  c;
    heater_cmd_t r;
    longint      span;
    longint      rise;
    longint      frac;
    c = active_cfg();
    case (op)
      OP_START: begin
        cur_phase  = PH_PREHEAT;
        elapsed_ms = '0;
        base_temp  = temp;
      end
      OP_ABORT: begin
        cur_phase  = PH_IDLE;
        elapsed_ms = '0;
        base_temp  = '0;
      end
      OP_TICK: begin
        if (cur_phase != PH_IDLE) begin
          if (elapsed_ms != '1) elapsed_ms = elapsed_ms + 1'b1;
          if (elapsed_ms > c.runtime) begin
            cur_phase  = (cur_phase == PH_REFLOW) ? PH_IDLE : phase_e'(cur_phase + 2'd1);
            elapsed_ms = '0;
            base_temp  = (cur_phase == PH_IDLE) ? '0 : c.target;
          end
        end
      end
      default: ;
    endcase

    // The new phase decides the fields of the result item.
    c            = active_cfg();
    r.phase      = cur_phase;
    r.duty_valid = (cur_phase != PH_IDLE);
    r.duty_limit = '0;
    r.setpoint   = '0;
    if (cur_phase != PH_IDLE) begin
      r.duty_limit = (c.duty > DUTY_MAX) ? DUTY_MAX : c.duty;
      if (c.ramp == '0) begin
        r.setpoint = c.target;
      end else begin
        span = (elapsed_ms < c.ramp) ? elapsed_ms : c.ramp;
        rise = (longint'(c.target) - longint'(base_temp)) * span;
        if (rise >= 0) frac = rise / longint'(c.ramp);
        else frac = -((-rise + longint'(c.ramp) - 1) / longint'(c.ramp));
        r.setpoint = TEMP_W'(longint'(base_temp) + frac);
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    heater_cmd_t want;
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) profile[i] = '0;
      cur_phase  = PH_IDLE;
      elapsed_ms = '0;
      base_temp  = '0;
      expected_cmds.delete();
      fails = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i && cfg_idx_i <= REG_REFLOW) begin
        profile[cfg_idx_i] = phase_cfg_t'(cfg_wdata_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_cmds.size() == 0) begin
          $error("result item with nothing expected: setpoint %0d, phase %0d",
                 setpoint_i, phase_i);
          fails++;
        end else begin
          want = expected_cmds.pop_front();
          if (setpoint_i !== want.setpoint) begin
            $error("setpoint: expected %0d, actual %0d", want.setpoint, setpoint_i);
            fails++;
          end
          if (phase_i !== want.phase) begin
            $error("phase: expected %0d, actual %0d", want.phase, phase_i);
            fails++;
          end
          if (duty_limit_i !== want.duty_limit) begin
            $error("duty_limit: expected %0d, actual %0d", want.duty_limit, duty_limit_i);
            fails++;
          end
          if (duty_valid_i !== want.duty_valid) begin
            $error("duty_valid: expected %0d, actual %0d", want.duty_valid, duty_valid_i);
            fails++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_cmds.push_back(next_heater_cmd(op_i, start_temp_i));
      end
      pending_o    <= expected_cmds.size();
      fail_count_o <= fails;
    end
  end

endmodule

// ===== bench/tb_reflow_profile_setpoint.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reflow profile setpoint testbench
// Drives start, tick, abort and unused op items into the sequencer under a
// series of phase profiles, from all zeros and all ones to short random
// ramps, with random gaps on the sender and stalls on the receiver. The
// checker beside the block predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module tb_reflow_profile_setpoint import rps_pkg::*; ();

  localparam logic [1:0] OP_UNUSED     = 2'd3;
  localparam int         SETTLE_CYCLES = 30;
  localparam int         STALL_LIMIT   = 2000;
  localparam int         RANDOM_ITEMS  = 1600;
  localparam int         NUM_PROFILES  = 10;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_valid   = 1'b0;
  logic              in_ready;
  logic [1:0]        op_d       = OP_TICK;
  logic [TEMP_W-1:0] start_temp = '0;
  logic              out_valid;
  logic              out_ready  = 1'b0;
  logic [TEMP_W-1:0] setpoint;
  logic [1:0]        phase;
  logic [DUTY_W-1:0] duty_limit;
  logic              duty_valid;
  logic              cfg_we     = 1'b0;
  logic [1:0]        cfg_idx    = REG_PREHEAT;
  logic [CFG_W-1:0]  cfg_wdata  = '0;

  int pending;
  int fail_count;
  int items_sent  = 0;
  int stall_left  = 0;
  int quiet_count = 0;
  bit idle_on     = 1'b1;

  always #2 clk = ~clk;

  reflow_profile_setpoint u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .op_i         (op_d),
    .start_temp_i (start_temp),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .setpoint_o   (setpoint),
    .phase_o      (phase),
    .duty_limit_o (duty_limit),
    .duty_valid_o (duty_valid),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata)
  );

  reflow_profile_setpoint_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .op_i         (op_d),
    .start_temp_i (start_temp),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .setpoint_i   (setpoint),
    .phase_i      (phase),
    .duty_limit_i (duty_limit),
    .duty_valid_i (duty_valid),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 16);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_count <= 0;
    end else if (quiet_count == STALL_LIMIT) begin
      $display("reflow_profile_setpoint test failed");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [TEMP_W-1:0] temp);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    op_d       <= op;
    start_temp <= temp;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input phase_cfg_t value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  task automatic load_profile(input phase_cfg_t pre, input phase_cfg_t soak,
                              input phase_cfg_t reflow);
    write_reg(REG_PREHEAT, pre);
    write_reg(REG_SOAK, soak);
    write_reg(REG_REFLOW, reflow);
    cfg_we <= 1'b0;
  endtask

  function automatic phase_cfg_t random_phase();
    phase_cfg_t c;
    c.target  = TEMP_W'($urandom_range(0, 511));
    c.duty    = DUTY_W'($urandom_range(0, 127));
    c.ramp    = RAMP_W'($urandom_range(0, 24));
    c.runtime = RAMP_W'($urandom_range(0, 30));
    case ($urandom_range(0, 9))
      0: c.ramp = '0;
      1: c.ramp = RAMP_W'($urandom);
      2: c.runtime = '1;
      3: c.ramp = '1;
      default: ;
    endcase
    return c;
  endfunction

  initial begin
    int quota;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // With every register at zero, each tick ends the phase at once.
    send_item(OP_TICK, '0);
    send_item(OP_UNUSED, '1);
    send_item(OP_ABORT, '0);
    send_item(OP_START, '0);
    repeat (4) send_item(OP_TICK, '0);
    send_item(OP_START, '1);
    send_item(OP_ABORT, '1);
    drain();

    // Clamped duties, a ramp down over the longest ramp and a reflow phase
    // whose runtime the timer can never pass.
    load_profile('{DUTY_W'(127), RAMP_W'(2), RAMP_W'(3), TEMP_W'(511)},
                 '{DUTY_W'(101), RAMP_W'(4), '1, TEMP_W'(0)},
                 '{DUTY_W'(0), '1, RAMP_W'(0), TEMP_W'(300)});
    send_item(OP_START, '0);
    repeat (9) send_item(OP_TICK, '0);
    send_item(OP_UNUSED, '0);
    send_item(OP_START, '1);
    send_item(OP_ABORT, '0);
    drain();

    for (int s = 0; s < NUM_PROFILES; s++) begin
      if (s == 0) load_profile('1, '1, '1);
      else if (s == 1) load_profile('0, '0, '0);
      else load_profile(random_phase(), random_phase(), random_phase());
      quota = items_sent + RANDOM_ITEMS / NUM_PROFILES;
      while (items_sent < quota) begin
        idle_on = (s < NUM_PROFILES - 2) && ($urandom_range(0, 2) != 0);
        if ($urandom_range(0, 99) < 80) begin
          send_item(OP_START, TEMP_W'($urandom));
          repeat ($urandom_range(1, 90)) begin
            if (items_sent >= quota) break;
            case ($urandom_range(0, 59))
              0:       send_item(OP_ABORT, TEMP_W'($urandom));
              1:       send_item(OP_UNUSED, TEMP_W'($urandom));
              2:       send_item(OP_START, TEMP_W'($urandom));
              default: send_item(OP_TICK, TEMP_W'($urandom));
            endcase
          end
        end else begin
          send_item(2'($urandom_range(0, 3)), TEMP_W'($urandom));
        end
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("reflow_profile_setpoint test passed");
    end else begin
      $display("reflow_profile_setpoint test failed");
    end
    $finish;
  end

endmodule

// ===== reflow_profile_setpoint.f =====
hw/rtl/rps_pkg.sv
hw/rtl/rps_cfg_regs.sv
hw/rtl/rps_ramp_unit.sv
hw/rtl/reflow_profile_setpoint.sv
bench/reflow_profile_setpoint_checker.sv
bench/tb_reflow_profile_setpoint.sv
